// File: hdl/nlq_pkg.sv
// shared types, constants and result codes for the neighbour link-quality table
`timescale 1ns / 1ps

package nlq_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int ADDR_BITS   = 16;

  // slot index and fill count widths
  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int USED_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [15:0] GAP_UNITY   = 16'h0100;
  localparam logic [3:0]  VERSION_ONE = 4'h1;

  // result status codes
  localparam logic [2:0] ST_KNOWN = 3'd0;
  localparam logic [2:0] ST_NEW   = 3'd1;
  localparam logic [2:0] ST_BAD   = 3'd2;
  localparam logic [2:0] ST_OWN   = 3'd3;
  localparam logic [2:0] ST_FULL  = 3'd4;

  // one table slot as held in the table ram
  typedef struct packed {
    logic [ADDR_BITS-1:0] addr;
    logic [7:0]           last_seq;
    logic [15:0]          avg_gap;
    logic [7:0]           rssi;
    logic [7:0]           lqi;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic ignore;
    logic scan_start;
    logic scan_step;
    logic hit;
    logic miss;
    logic full;
    logic update;
    logic emit;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic hdr_bad;
    logic own_match;
    logic match;
    logic scan_done;
    logic table_full;
    logic out_free;
  } stat_t;

endpackage

// File: hdl/nlq_ram.sv
// generic single write port ram with one registered read port
`timescale 1ns / 1ps

module nlq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/nlq_ctrl.sv
// controller state machine sequencing check, scan, update and result transfer
`timescale 1ns / 1ps

module nlq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  nlq_pkg::stat_t stat,
  output nlq_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_UPD   = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.hdr_bad || stat.own_match) begin
          cmd.ignore = 1'b1;
          state_next = S_EMIT;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.match) begin
          cmd.hit    = 1'b1;
          state_next = S_UPD;
        end else if (stat.scan_done) begin
          if (stat.table_full) begin
            cmd.full   = 1'b1;
            state_next = S_EMIT;
          end else begin
            cmd.miss   = 1'b1;
            state_next = S_UPD;
          end
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/nlq_dp.sv
// datapath: header checks, table ram and scan, gap average, result registers
`timescale 1ns / 1ps

module nlq_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  nlq_pkg::cmd_t                 cmd,
  output nlq_pkg::stat_t                stat,
  input  logic [nlq_pkg::ADDR_BITS-1:0] own_address,
  input  logic [nlq_pkg::ADDR_BITS-1:0] src_addr,
  input  logic [3:0]                    version,
  input  logic [3:0]                    hop_limit,
  input  logic [7:0]                    seqno,
  input  logic [7:0]                    rssi,
  input  logic [7:0]                    lqi,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    status,
  output logic [5:0]                    entry_index,
  output logic [7:0]                    seq_gap,
  output logic [15:0]                   avg_gap,
  output logic [15:0]                   ignored_total
);

  // captured header
  logic [nlq_pkg::ADDR_BITS-1:0] src_q;
  logic [3:0]                    ver_q;
  logic [3:0]                    hops_q;
  logic [7:0]                    seq_q;
  logic [7:0]                    rssi_q;
  logic [7:0]                    lqi_q;

  logic [nlq_pkg::USED_W-1:0] used;
  logic [15:0]                ignore_cnt;

  // scan
  logic [nlq_pkg::USED_W-1:0] scan_idx;
  logic [nlq_pkg::IDX_W-1:0]  rd_idx;
  logic                       rd_pend;
  logic                       issue;
  nlq_pkg::entry_t            rd_entry;

  // slot being updated
  logic [nlq_pkg::IDX_W-1:0] hit_idx;
  logic [7:0]                ent_last;
  logic [15:0]               ent_avg;
  logic                      ent_new;

  // pending result
  logic [2:0]  res_status;
  logic [5:0]  res_idx;
  logic [7:0]  res_gap;
  logic [15:0] res_avg;

  logic [7:0]      gap;
  logic [17:0]     avg_x3;
  logic [16:0]     avg_sum;
  nlq_pkg::entry_t wr_entry;

  assign issue = cmd.scan_step && (scan_idx < used);

  nlq_ram #(
    .WIDTH(nlq_pkg::ENTRY_W),
    .DEPTH(nlq_pkg::TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (cmd.update),
    .waddr(hit_idx),
    .wdata(wr_entry),
    .re   (issue),
    .raddr(scan_idx[nlq_pkg::IDX_W-1:0]),
    .rdata(rd_entry)
  );

  // new average: gap*64 + floor(avg*3/4), stays within 16 bits from a start of unity
  assign gap     = seq_q - ent_last;
  assign avg_x3  = {2'b00, ent_avg} + {1'b0, ent_avg, 1'b0};
  assign avg_sum = {3'b000, gap, 6'b000000} + {1'b0, avg_x3[17:2]};

  always_comb begin
    wr_entry.addr     = src_q;
    wr_entry.last_seq = seq_q;
    wr_entry.avg_gap  = avg_sum[15:0];
    wr_entry.rssi     = rssi_q;
    wr_entry.lqi      = lqi_q;
  end

  assign stat.hdr_bad    = (ver_q != nlq_pkg::VERSION_ONE) || (hops_q == 4'd0);
  assign stat.own_match  = (src_q == own_address);
  assign stat.match      = rd_pend && (rd_entry.addr == src_q);
  assign stat.scan_done  = !rd_pend && (scan_idx == used);
  assign stat.table_full = (used == nlq_pkg::USED_W'(nlq_pkg::TABLE_DEPTH));
  assign stat.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      src_q  <= src_addr;
      ver_q  <= version;
      hops_q <= hop_limit;
      seq_q  <= seqno;
      rssi_q <= rssi;
      lqi_q  <= lqi;
    end

    if (cmd.scan_step) begin
      rd_idx <= scan_idx[nlq_pkg::IDX_W-1:0];
    end

    if (cmd.hit) begin
      hit_idx  <= rd_idx;
      ent_last <= rd_entry.last_seq;
      ent_avg  <= rd_entry.avg_gap;
      ent_new  <= 1'b0;
    end else if (cmd.miss) begin
      hit_idx  <= used[nlq_pkg::IDX_W-1:0];
      ent_last <= seq_q - 8'd1;
      ent_avg  <= nlq_pkg::GAP_UNITY;
      ent_new  <= 1'b1;
    end

    if (cmd.ignore) begin
      res_status <= stat.hdr_bad ? nlq_pkg::ST_BAD : nlq_pkg::ST_OWN;
      res_idx    <= '0;
      res_gap    <= '0;
      res_avg    <= '0;
    end else if (cmd.full) begin
      res_status <= nlq_pkg::ST_FULL;
      res_idx    <= '0;
      res_gap    <= '0;
      res_avg    <= '0;
    end else if (cmd.update) begin
      res_status <= ent_new ? nlq_pkg::ST_NEW : nlq_pkg::ST_KNOWN;
      res_idx    <= 6'(hit_idx);
      res_gap    <= gap;
      res_avg    <= avg_sum[15:0];
    end

    if (cmd.emit) begin
      status        <= res_status;
      entry_index   <= res_idx;
      seq_gap       <= res_gap;
      avg_gap       <= res_avg;
      ignored_total <= ignore_cnt;
    end

    if (rst) begin
      used       <= '0;
      ignore_cnt <= '0;
      scan_idx   <= '0;
      rd_pend    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.ignore) begin
        ignore_cnt <= ignore_cnt + 16'd1;
      end
      if (cmd.miss) begin
        used <= used + 1'b1;
      end
      if (cmd.scan_start) begin
        scan_idx <= '0;
        rd_pend  <= 1'b0;
      end else if (cmd.scan_step) begin
        rd_pend <= issue;
        if (issue) begin
          scan_idx <= scan_idx + 1'b1;
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: hdl/neighbor_link_quality_table.sv
// top level of the neighbour link-quality table: configuration port and block wiring
`timescale 1ns / 1ps

// Keeps a table of up to 64 neighbours heard on received broadcast headers.
// Each header transfer gives exactly one result transfer. Headers with a
// version other than 1 or a hop limit of zero report status 2, headers from
// own_address report status 3; both bump a wrapping 16-bit ignore counter.
// A known sender has rssi and lqi stored and its 8.8 average sequence gap
// updated (status 0); an unknown sender takes the next free slot (status 1),
// or is dropped with status 4 when all slots are taken. Table slots are
// filled in order and tracked by a fill count, so no clearing pass runs after
// reset and the block is ready at once. The table ram is searched serially,
// one slot compared per cycle through its single read port. A new header is
// taken while the previous result still waits at the output.
// own_address sits at byte address 0 of the configuration port and should
// only be written while no header is in flight.

module neighbor_link_quality_table (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // header input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] src_addr,
  input  logic [3:0]  version,
  input  logic [3:0]  hop_limit,
  input  logic [7:0]  seqno,
  input  logic [7:0]  rssi,
  input  logic [7:0]  lqi,
  // result output
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [5:0]  entry_index,
  output logic [7:0]  seq_gap,
  output logic [15:0] avg_gap,
  output logic [15:0] ignored_total
);

  // register select bit of the byte address
  localparam logic REG_OWN_ADDRESS = 1'b0;

  logic [nlq_pkg::ADDR_BITS-1:0] own_address;
  logic                          cfg_write;
  nlq_pkg::cmd_t                 cmd;
  nlq_pkg::stat_t                stat;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  // own address register, write completes in the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= '0;
    end else if (cfg_write && (paddr[2] == REG_OWN_ADDRESS)) begin
      own_address <= pwdata[nlq_pkg::ADDR_BITS-1:0];
    end
  end

  // read back, unknown registers read as zero
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_OWN_ADDRESS) begin
      prdata[nlq_pkg::ADDR_BITS-1:0] = own_address;
    end
  end

  // sequencing of check, table search, update and result transfer
  nlq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  // header registers, table ram, average arithmetic and output register
  nlq_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .own_address  (own_address),
    .src_addr     (src_addr),
    .version      (version),
    .hop_limit    (hop_limit),
    .seqno        (seqno),
    .rssi         (rssi),
    .lqi          (lqi),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .entry_index  (entry_index),
    .seq_gap      (seq_gap),
    .avg_gap      (avg_gap),
    .ignored_total(ignored_total)
  );

endmodule
